[hw/rtl/vcp_pkg.sv]
// vcp_pkg: shared types, constants and helpers of the voltage clamp pid block
// used by vcp_mulq, vcp_seq and voltage_clamp_pid; no dependencies
package vcp_pkg;

  // q16.16 one and the wide saturation bound of the products
  localparam logic [16:0] QONE   = 17'd65536;
  localparam int          ADDR_W = 5;
  // working width of the accumulators
  localparam int          ACC_W  = 52;
  localparam int          B_W    = 34;
  localparam int          BMAG_W = B_W - 1;
  localparam int          HI_W   = ACC_W - 32;
  localparam int          PROD_W = ACC_W + BMAG_W;
  localparam int          MAG_W  = 62;
  localparam logic [MAG_W-1:0] WLIM = 62'h2000_0000_0000_0000;

  localparam logic signed [63:0] S32_MAX = 64'sh0000_0000_7fff_ffff;
  localparam logic signed [63:0] S32_MIN = -64'sh0000_0000_8000_0000;

  typedef enum logic [2:0] {
    REG_TARGET = 3'd0,
    REG_MODE   = 3'd1,
    REG_PROP   = 3'd2,
    REG_INTEG  = 3'd3,
    REG_DERIV  = 3'd4,
    REG_FILT   = 3'd5,
    REG_DECAY  = 3'd6
  } vcp_reg_e;

  typedef enum logic [1:0] {
    MODE_ERR    = 2'd0,
    MODE_DMEAS  = 2'd1,
    MODE_PDMEAS = 2'd2,
    MODE_HOLD   = 2'd3
  } vcp_mode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_FOLD,
    ST_ACCUM,
    ST_DONE
  } vcp_state_e;

  // one multiply-accumulate step each
  typedef enum logic [3:0] {
    OP_INNER,
    OP_FEED,
    OP_DECAY,
    OP_E0,
    OP_EL0,
    OP_H2,
    OP_E1,
    OP_E2,
    OP_DD,
    OP_KP
  } vcp_op_e;

  typedef struct packed {
    logic load;
    logic lo;
    logic hi;
    logic fold;
  } vcp_mul_ctl_t;

  typedef struct packed {
    vcp_mul_ctl_t mul;
    logic         accum;
    logic         commit;
    logic         out_load;
    logic         idle;
    vcp_op_e      op;
  } vcp_seq_t;

  function automatic logic signed [31:0] vcp_sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > S32_MAX) begin
      r = 32'sh7fff_ffff;
    end else if (v < S32_MIN) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic vcp_is_last(input vcp_op_e op, input vcp_mode_e mode);
    return (op == OP_KP) || ((op == OP_DECAY) && (mode == MODE_HOLD));
  endfunction

  function automatic vcp_op_e vcp_next_op(input vcp_op_e op, input vcp_mode_e mode);
    vcp_op_e n;
    case (op)
      OP_INNER: n = OP_FEED;
      OP_FEED:  n = OP_DECAY;
      OP_DECAY: begin
        case (mode)
          MODE_ERR:    n = OP_E0;
          MODE_DMEAS:  n = OP_E1;
          MODE_PDMEAS: n = OP_E2;
          default:     n = OP_KP;
        endcase
      end
      OP_E0:    n = OP_EL0;
      OP_EL0:   n = OP_H2;
      OP_H2:    n = OP_KP;
      OP_E1:    n = OP_DD;
      OP_E2:    n = OP_DD;
      default:  n = OP_KP;
    endcase
    return n;
  endfunction

endpackage

[hw/rtl/vcp_mulq.sv]
// vcp_mulq: shared sign-magnitude q16.16 multiplier, two 32x33 partial products
// depends on vcp_pkg
module vcp_mulq (
  input  logic                              clk_i,
  input  vcp_pkg::vcp_mul_ctl_t             ctl_i,
  input  logic signed [vcp_pkg::ACC_W-1:0]  a_i,
  input  logic signed [vcp_pkg::B_W-1:0]    b_i,
  output logic        [vcp_pkg::MAG_W-1:0]  mag_o,
  output logic                              neg_o
);
  import vcp_pkg::*;

  logic [ACC_W-1:0]      amag_q;
  logic [BMAG_W-1:0]     bmag_q;
  logic                  neg_q;
  logic [31:0]           mop;
  logic [31+BMAG_W:0]    prod;
  logic [31+BMAG_W:0]    plo_q;
  logic [HI_W+BMAG_W-1:0] phi_q;
  logic [PROD_W-1:0]     full;
  logic [PROD_W-17:0]    shifted;
  logic [ACC_W-1:0]      amag_d;
  logic [B_W-1:0]        bneg;
  logic [MAG_W-1:0]      mag_q;

  assign amag_d = a_i[ACC_W-1] ? (~a_i + 1'b1) : a_i;
  assign bneg   = ~b_i + 1'b1;

  // low chunk first, then the high chunk through the same multiplier
  assign mop  = ctl_i.hi ? 32'(amag_q[ACC_W-1:32]) : amag_q[31:0];
  assign prod = {{BMAG_W{1'b0}}, mop} * {32'b0, bmag_q};

  assign full    = {phi_q, 32'b0} + {{HI_W{1'b0}}, plo_q};
  assign shifted = full[PROD_W-1:16];

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      amag_q <= amag_d;
      bmag_q <= b_i[B_W-1] ? bneg[BMAG_W-1:0] : b_i[BMAG_W-1:0];
      neg_q  <= a_i[ACC_W-1] ^ b_i[B_W-1];
    end
    if (ctl_i.lo) begin
      plo_q <= prod;
    end
    if (ctl_i.hi) begin
      phi_q <= prod[HI_W+BMAG_W-1:0];
    end
    if (ctl_i.fold) begin
      mag_q <= (shifted > (PROD_W-16)'(WLIM)) ? WLIM : shifted[MAG_W-1:0];
    end
  end

  assign mag_o = mag_q;
  assign neg_o = neg_q;

endmodule

[hw/rtl/vcp_seq.sv]
// vcp_seq: sequencer stepping the multiply-accumulate ops of one sample
// depends on vcp_pkg
module vcp_seq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  vcp_pkg::vcp_mode_e  mode_i,
  input  logic                out_free_i,
  output vcp_pkg::vcp_seq_t   seq_o
);
  import vcp_pkg::*;

  vcp_state_e state_q, state_d;
  vcp_op_e    op_q, op_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      op_q    <= OP_INNER;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
    end
  end

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    seq_o   = '0;
    seq_o.op = op_q;
    case (state_q)
      ST_IDLE: begin
        seq_o.idle = 1'b1;
        if (start_i) begin
          op_d    = OP_INNER;
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        seq_o.mul.load = 1'b1;
        state_d = ST_MUL_LO;
      end
      ST_MUL_LO: begin
        seq_o.mul.lo = 1'b1;
        state_d = ST_MUL_HI;
      end
      ST_MUL_HI: begin
        seq_o.mul.hi = 1'b1;
        state_d = ST_FOLD;
      end
      ST_FOLD: begin
        seq_o.mul.fold = 1'b1;
        state_d = ST_ACCUM;
      end
      ST_ACCUM: begin
        seq_o.accum = 1'b1;
        if (vcp_is_last(op_q, mode_i)) begin
          seq_o.commit = 1'b1;
          state_d = ST_DONE;
        end else begin
          op_d    = vcp_next_op(op_q, mode_i);
          state_d = ST_LOAD;
        end
      end
      ST_DONE: begin
        // hold until the output register can take the beat
        if (out_free_i) begin
          seq_o.out_load = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

[hw/rtl/voltage_clamp_pid.sv]
// voltage_clamp_pid: command filter and velocity-form pid, one shared multiplier.
// each op runs load, low product, high product, fold, accumulate in turn;
// 7 ops in loop mode 0, 6 in modes 1 and 2, 3 in mode 3.
// no new input beat is taken until the result enters the output register, which
// waits while the sink stalls; all ops share the single 32x33 multiplier.
// async active-low reset zeroes histories, cmd and cur; registers get their defaults.
module voltage_clamp_pid (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [vcp_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic signed [31:0]          measured_voltage_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic signed [31:0]          clamp_current_o,
  output logic signed [31:0]          command_voltage_o
);
  import vcp_pkg::*;

  // configuration
  logic signed [31:0] target_q;
  vcp_mode_e          mode_q;
  logic [30:0]        kp_q, ki_q, kd_q, kf_q;
  logic [16:0]        ke_q;

  // loop state
  logic signed [31:0] cmd_q, prev_q, el_q, h2_q, ml_q, cur_q;
  logic signed [31:0] v_q;
  logic signed [ACC_W-1:0] tmp_q, acc_q;

  logic signed [31:0] clamp_q, command_q;
  logic               out_valid_q;

  vcp_seq_t           seq;
  vcp_reg_e           reg_idx;
  logic               cfg_wr;
  logic               in_accept;
  logic               out_free;

  logic signed [32:0] d_w, ct_w, ediff_w;
  logic signed [31:0] e_w;
  logic signed [34:0] dd_w;
  logic signed [B_W-1:0] b_f, b_feed, b_e0, b_el0, b_e1;
  logic signed [ACC_W-1:0] a_sel;
  logic signed [B_W-1:0]   b_sel;
  logic signed [63:0]      base_w, sum_w, mag_ext;
  logic                    op_sub;
  logic [MAG_W-1:0]        mul_mag;
  logic                    mul_neg;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign reg_idx = vcp_reg_e'(paddr[ADDR_W-1:2]);

  always_comb begin
    case (reg_idx)
      REG_TARGET: prdata = target_q;
      REG_MODE:   prdata = 32'(mode_q);
      REG_PROP:   prdata = 32'(kp_q);
      REG_INTEG:  prdata = 32'(ki_q);
      REG_DERIV:  prdata = 32'(kd_q);
      REG_FILT:   prdata = 32'(kf_q);
      REG_DECAY:  prdata = 32'(ke_q);
      default:    prdata = '0;
    endcase
  end

  assign in_stall_o = !seq.idle;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  vcp_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (in_accept),
    .mode_i     (mode_q),
    .out_free_i (out_free),
    .seq_o      (seq)
  );

  // operands
  assign d_w     = 33'(target_q) - 33'(prev_q);
  assign ct_w    = 33'(cmd_q) - 33'(target_q);
  assign ediff_w = 33'(cmd_q) - 33'(v_q);
  assign e_w     = vcp_sat32(64'(ediff_w));
  assign dd_w    = 35'(v_q) - (35'(ml_q) <<< 1) + 35'(h2_q);

  assign b_f    = B_W'(kf_q);
  assign b_feed = B_W'(QONE) - B_W'(kf_q);
  assign b_e0   = B_W'(QONE) + B_W'(ki_q) + B_W'(kd_q);
  assign b_el0  = B_W'(QONE) + {2'b0, kd_q, 1'b0};
  assign b_e1   = B_W'(QONE) + B_W'(ki_q);

  always_comb begin
    case (seq.op)
      OP_INNER: begin a_sel = ACC_W'(d_w);   b_sel = b_f;          end
      OP_FEED:  begin a_sel = ACC_W'(d_w);   b_sel = b_feed;       end
      OP_DECAY: begin a_sel = tmp_q;         b_sel = B_W'(ke_q);   end
      OP_E0:    begin a_sel = ACC_W'(e_w);   b_sel = b_e0;         end
      OP_EL0:   begin a_sel = ACC_W'(el_q);  b_sel = b_el0;        end
      OP_H2:    begin a_sel = ACC_W'(h2_q);  b_sel = B_W'(kd_q);   end
      OP_E1:    begin a_sel = ACC_W'(e_w);   b_sel = b_e1;         end
      OP_E2:    begin a_sel = ACC_W'(e_w);   b_sel = B_W'(ki_q);   end
      OP_DD:    begin a_sel = ACC_W'(dd_w);  b_sel = B_W'(kd_q);   end
      default:  begin a_sel = acc_q;         b_sel = B_W'(kp_q);   end
    endcase
  end

  vcp_mulq u_mulq (
    .clk_i (clk_i),
    .ctl_i (seq.mul),
    .a_i   (a_sel),
    .b_i   (b_sel),
    .mag_o (mul_mag),
    .neg_o (mul_neg)
  );

  // base term each product is added to; the el0 and dd terms enter subtracted
  always_comb begin
    op_sub = 1'b0;
    case (seq.op)
      OP_INNER: base_w = 64'(ct_w);
      OP_FEED:  base_w = 64'(target_q);
      OP_E0:    base_w = '0;
      OP_E1:    base_w = 64'sd0 - 64'(el_q);
      OP_E2:    base_w = 64'(ml_q) - 64'(v_q);
      OP_EL0: begin
        base_w = 64'(acc_q);
        op_sub = 1'b1;
      end
      OP_DD: begin
        base_w = 64'(acc_q);
        op_sub = 1'b1;
      end
      OP_KP:    base_w = 64'(cur_q);
      default:  base_w = 64'(acc_q);
    endcase
  end

  assign mag_ext = {2'b0, mul_mag};
  assign sum_w   = (op_sub ^ mul_neg) ? (base_w - mag_ext) : (base_w + mag_ext);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q    <= '0;
      mode_q      <= MODE_ERR;
      kp_q        <= 31'(QONE);
      ki_q        <= 31'(QONE);
      kd_q        <= '0;
      kf_q        <= 31'd327680;
      ke_q        <= 17'd53656;
      cmd_q       <= '0;
      prev_q      <= '0;
      el_q        <= '0;
      h2_q        <= '0;
      ml_q        <= '0;
      cur_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_wr) begin
        case (reg_idx)
          REG_TARGET: target_q <= pwdata;
          REG_MODE:   mode_q   <= vcp_mode_e'(pwdata[1:0]);
          REG_PROP:   kp_q     <= pwdata[30:0];
          REG_INTEG:  ki_q     <= pwdata[30:0];
          REG_DERIV:  kd_q     <= pwdata[30:0];
          REG_FILT:   kf_q     <= pwdata[30:0];
          REG_DECAY:  ke_q     <= (pwdata[16:0] > QONE) ? QONE : pwdata[16:0];
          default: ;
        endcase
      end
      if (seq.accum && (seq.op == OP_DECAY)) begin
        cmd_q <= vcp_sat32(sum_w);
      end
      if (seq.accum && (seq.op == OP_KP)) begin
        cur_q <= vcp_sat32(sum_w);
      end
      if (seq.commit) begin
        prev_q <= target_q;
        case (mode_q)
          MODE_ERR: begin
            h2_q <= el_q;
            el_q <= e_w;
          end
          MODE_DMEAS: begin
            h2_q <= ml_q;
            ml_q <= v_q;
            el_q <= e_w;
          end
          MODE_PDMEAS: begin
            h2_q <= ml_q;
            ml_q <= v_q;
          end
          default: ;
        endcase
      end
      if (seq.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      v_q <= measured_voltage_i;
    end
    if (seq.accum && (seq.op == OP_INNER)) begin
      tmp_q <= sum_w[ACC_W-1:0];
    end
    if (seq.accum && (seq.op != OP_INNER) && (seq.op != OP_DECAY) && (seq.op != OP_KP)) begin
      acc_q <= sum_w[ACC_W-1:0];
    end
    if (seq.out_load) begin
      clamp_q   <= cur_q;
      command_q <= cmd_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign clamp_current_o   = clamp_q;
  assign command_voltage_o = command_q;

`ifndef SYNTHESIS
  // an accepted beat keeps the input side closed until its result is out
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> in_stall_o)
    else $error("input taken while a sample is in flight");

  // a finished result never overwrites a beat still held by the sink
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    seq.out_load |-> !(out_valid_q && out_stall_i))
    else $error("result register overwritten while stalled");

  // folded product magnitude stays within the wide saturation bound
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    seq.mul.fold |=> (mul_mag <= WLIM))
    else $error("product magnitude above saturation bound");

  // loop histories only move on the commit of a sample
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !seq.commit |=> ($stable(prev_q) && $stable(el_q) && $stable(h2_q) && $stable(ml_q)))
    else $error("loop history changed outside commit");
`endif

endmodule
